// ----- rtl/hpf3_pkg.sv -----
package hpf3_pkg;

   localparam int PIXEL_W      = 16;
   localparam int ROW_W        = 16;
   localparam int COL_OUT_W    = 10;
   localparam int VALUE_W      = 20;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 16;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_PIXEL_BITS = 16;

   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(640);
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(480);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // One bit per possible result of a pixel, lowest bit goes out first.
   typedef struct packed {
      logic frame_end;
      logic last_row;
      logic row_end;
      logic interior;
   } result_mask_type;

endpackage

// ----- rtl/hpf3_req_if.sv -----
interface hpf3_req_if;
   import hpf3_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

// ----- rtl/hpf3_rsp_if.sv -----
interface hpf3_rsp_if;
   import hpf3_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [ROW_W-1:0]            out_row;
   logic [COL_OUT_W-1:0]        out_col;
   logic signed [VALUE_W-1:0]   value;
   logic                        run_last;
   logic                        frame_last;

   modport source (output valid, output out_row, output out_col, output value,
                   output run_last, output frame_last, input ready);
   modport sink   (input valid, input out_row, input out_col, input value,
                   input run_last, input frame_last, output ready);
endinterface

// ----- rtl/hpf3_csr_if.sv -----
interface hpf3_csr_if;
   import hpf3_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/image_3x3_highpass_filter.sv -----
// Channel  | Interface    | Direction | Beat carries
// req_if   | hpf3_req_if  | in        | pixel, raster order
// rsp_if   | hpf3_rsp_if  | out       | out_row, out_col, value, run_last, frame_last
// csr_if   | hpf3_csr_if  | in        | index, data (register write)
//
// A pixel beat is taken every cycle unless the result stage stalls; it passes first through
// the input stage, where the line-store read returns, and then the result stage, which holds
// it for its result beats, at most four (most pixels give exactly one, first-row pixels none). The result stage's
// single output beat per cycle sets the rate. Reset is synchronous; it returns the
// position counters to the first pixel and the registers to 640 by 480. A stalled result
// stage holds the input stage, which then drops req ready. Register writes are always taken.
module image_3x3_highpass_filter #(
   parameter int MAX_WIDTH  = hpf3_pkg::DEF_MAX_WIDTH,
   parameter int PIXEL_BITS = hpf3_pkg::DEF_PIXEL_BITS
) (
   input  logic          clock,
   input  logic          reset,
   hpf3_req_if.sink      req_if,
   hpf3_rsp_if.source    rsp_if,
   hpf3_csr_if.sink      csr_if
);
   import hpf3_pkg::*;

   localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
   localparam int CS_W  = PIXEL_BITS + 2;
   localparam int SUM_W = PIXEL_BITS + 4;
   localparam int DIF_W = PIXEL_BITS + 5;

   logic [CFG_WIDTH_W-1:0]  width_ff;
   logic [CFG_HEIGHT_W-1:0] height_ff;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] w_m1, x_cur;
   logic [ROW_W-1:0] h_m1, y_cur;

   logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
   logic [2*PIXEL_BITS-1:0] rd_ff;

   logic                  s1_valid_ff, s1_valid_in;
   logic [PIXEL_BITS-1:0] s1_pix_ff;
   logic [COL_W-1:0]      s1_x_ff, s1_w_m1_ff;
   logic [ROW_W-1:0]      s1_y_ff, s1_h_m1_ff;

   logic [CS_W-1:0]       cs0_ff, cs1_ff;
   logic [PIXEL_BITS-1:0] ctr_ff;

   result_mask_type          s2_mask_ff, s2_mask_in, new_mask;
   logic [ROW_W-1:0]         s2_row_a_ff, s2_row_b_ff;
   logic [COL_W-1:0]         s2_col_a_ff, s2_col_b_ff;
   logic signed [VALUE_W-1:0] s2_value_ff;

   logic req_acc, rsp_acc, s2_free, s1_adv, s2_last;
   logic [PIXEL_BITS-1:0] rd_a, rd_b;
   logic [CS_W-1:0]       cs_cur;
   logic [SUM_W-1:0]      win_sum, nine_ctr;
   logic signed [DIF_W-1:0] diff;
   logic signed [VALUE_W-1:0] value_new;
   logic [COL_W-1:0] rsp_col;

   // Effective frame size.
   always_comb begin
      priority if (width_ff < CFG_WIDTH_W'(3)) begin
         w_m1 = COL_W'(2);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_m1 = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_m1 = COL_W'(width_ff - CFG_WIDTH_W'(1));
      end
      if (height_ff < CFG_HEIGHT_W'(3)) begin
         h_m1 = ROW_W'(2);
      end else begin
         h_m1 = height_ff - ROW_W'(1);
      end
      x_cur = (col_ff > w_m1) ? w_m1 : col_ff;
      y_cur = (row_ff > h_m1) ? h_m1 : row_ff;
   end

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_if.data[CFG_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_if.data[CFG_HEIGHT_W-1:0];
         endcase
      end
   end

   // Handshakes.
   assign s2_last  = $onehot(s2_mask_ff);
   assign rsp_acc  = rsp_if.valid && rsp_if.ready;
   assign s2_free  = (s2_mask_ff == '0) || (rsp_acc && s2_last);
   assign s1_adv   = s1_valid_ff && s2_free;
   assign req_if.ready = !s1_valid_ff || s2_free;
   assign req_acc  = req_if.valid && req_if.ready;

   // Position counters.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_acc) begin
         if (x_cur == w_m1) begin
            col_in = '0;
            row_in = (y_cur == h_m1) ? '0 : y_cur + ROW_W'(1);
         end else begin
            col_in = x_cur + COL_W'(1);
            row_in = y_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line store: older row in the upper half, newer row in the lower half.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_ff <= line_mem[x_cur];
      end
      if (s1_adv) begin
         line_mem[s1_x_ff] <= {rd_b, s1_pix_ff};
      end
   end

   assign rd_a = rd_ff[2*PIXEL_BITS-1:PIXEL_BITS];
   assign rd_b = rd_ff[PIXEL_BITS-1:0];

   // Input stage.
   assign s1_valid_in = req_acc || (s1_valid_ff && !s2_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_pix_ff  <= req_if.pixel[PIXEL_BITS-1:0];
         s1_x_ff    <= x_cur;
         s1_y_ff    <= y_cur;
         s1_w_m1_ff <= w_m1;
         s1_h_m1_ff <= h_m1;
      end
   end

   // Window arithmetic: column sums of the two previous columns plus the current one, against nine times the centre.
   always_comb begin
      cs_cur    = CS_W'(rd_a) + CS_W'(rd_b) + CS_W'(s1_pix_ff);
      win_sum   = SUM_W'(cs0_ff) + SUM_W'(cs1_ff) + SUM_W'(cs_cur);
      nine_ctr  = (SUM_W'(ctr_ff) << 3) + SUM_W'(ctr_ff);
      diff      = $signed({1'b0, nine_ctr}) - $signed({1'b0, win_sum});
      if (s1_y_ff >= ROW_W'(2) && s1_x_ff >= COL_W'(2)) begin
         value_new = VALUE_W'(diff);
      end else begin
         value_new = '0;
      end
      new_mask.interior  = (s1_y_ff != '0) && (s1_x_ff != '0);
      new_mask.row_end   = (s1_y_ff != '0) && (s1_x_ff == s1_w_m1_ff);
      new_mask.last_row  = (s1_y_ff == s1_h_m1_ff) && (s1_x_ff != '0);
      new_mask.frame_end = (s1_y_ff == s1_h_m1_ff) && (s1_x_ff == s1_w_m1_ff);
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         cs0_ff <= cs1_ff;
         cs1_ff <= cs_cur;
         ctr_ff <= rd_b;
      end
   end

   // Result stage: emits the pending results of one pixel, lowest bit first.
   always_comb begin
      s2_mask_in = s2_mask_ff;
      if (s1_adv) begin
         s2_mask_in = new_mask;
      end else if (s2_free) begin
         s2_mask_in = '0;
      end else if (rsp_acc) begin
         s2_mask_in = s2_mask_ff & (s2_mask_ff - 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_mask_ff <= '0;
      end else begin
         s2_mask_ff <= s2_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_row_a_ff <= s1_y_ff - ROW_W'(1);
         s2_col_a_ff <= s1_x_ff - COL_W'(1);
         s2_row_b_ff <= s1_h_m1_ff;
         s2_col_b_ff <= s1_w_m1_ff;
         s2_value_ff <= value_new;
      end
   end

   always_comb begin
      rsp_if.value      = '0;
      rsp_if.frame_last = 1'b0;
      priority if (s2_mask_ff.interior) begin
         rsp_if.out_row = s2_row_a_ff;
         rsp_col        = s2_col_a_ff;
         rsp_if.value   = s2_value_ff;
      end else if (s2_mask_ff.row_end) begin
         rsp_if.out_row = s2_row_a_ff;
         rsp_col        = s2_col_b_ff;
      end else if (s2_mask_ff.last_row) begin
         rsp_if.out_row = s2_row_b_ff;
         rsp_col        = s2_col_a_ff;
      end else begin
         rsp_if.out_row    = s2_row_b_ff;
         rsp_col           = s2_col_b_ff;
         rsp_if.frame_last = s2_mask_ff.frame_end;
      end
   end

   assign rsp_if.valid    = (s2_mask_ff != '0);
   assign rsp_if.out_col  = COL_OUT_W'(rsp_col);
   assign rsp_if.run_last = s2_last;

   // The frame-end beat is always the last one of its pixel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.frame_last |-> rsp_if.run_last)
      else $error("frame end beat not marked as end of run");

   // A beat that is not the last of its pixel is followed by another one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_acc && !rsp_if.run_last |=> rsp_if.valid)
      else $error("pending results lost");

   // A pixel at the row end wraps the column counter.
   assert property (@(posedge clock) disable iff (reset)
      req_acc && (x_cur == w_m1) |=> col_ff == '0)
      else $error("column counter did not wrap");

   // A held input stage keeps its pixel.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_free |=> s1_valid_ff && $stable(s1_pix_ff) && $stable(s1_x_ff))
      else $error("input stage changed while stalled");

endmodule
